// File: rtl/rti_pkg.sv
package rti_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned EdgeW  = 33;
	localparam int unsigned CrossW = 66;
	localparam int unsigned DotW   = 104;
	localparam int unsigned LoW    = 33;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [EdgeW-1:0]  edge_t;
	typedef logic signed [CrossW-1:0] cross_t;
	typedef logic signed [DotW-1:0]   dot_t;

	typedef enum logic [2:0] {
		VERDICT_HIT      = 3'd0,
		VERDICT_PARALLEL = 3'd1,
		VERDICT_U_OUT    = 3'd2,
		VERDICT_V_OUT    = 3'd3,
		VERDICT_BEHIND   = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_DET_MIN  = 3'd6
	} reg_index_t;

	localparam coord_t DirZReset = 32'sd65536;

endpackage

// File: rtl/ray_triangle_intersect_top.sv
// Moller-Trumbore ray/triangle test in exact fixed point. Load the ray origin,
// direction and det_min through the cfg port while the pipe is empty, then stream
// triangles (vertices a, b, c, signed Q16.16). Each triangle gives one item with
// hit and verdict (0 hit, 1 parallel, 2 u outside, 3 v outside, 4 behind origin).
// Throughput is one triangle per clock unless the output stalls; the pipe has eight
// stages: edges, 33x33 cross products, P/Q differences, split 33x66 dot partial
// products, partial recombine, 3-term sums (u+v has six), sign fold, compare.
// A stall on the output freezes the whole pipe; nothing is dropped or repeated.
module ray_triangle_intersect_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rti_pkg::coord_t       a_x,
	input  rti_pkg::coord_t       a_y,
	input  rti_pkg::coord_t       a_z,
	input  rti_pkg::coord_t       b_x,
	input  rti_pkg::coord_t       b_y,
	input  rti_pkg::coord_t       b_z,
	input  rti_pkg::coord_t       c_x,
	input  rti_pkg::coord_t       c_y,
	input  rti_pkg::coord_t       c_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output rti_pkg::verdict_t     verdict
);
	import rti_pkg::*;

	// ---- configuration registers ----
	coord_t      org_q [3];
	coord_t      dir_q [3];
	logic [30:0] det_min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0]  <= '0;
			org_q[1]  <= '0;
			org_q[2]  <= '0;
			dir_q[0]  <= '0;
			dir_q[1]  <= '0;
			dir_q[2]  <= DirZReset;
			det_min_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_ORIGIN_X: org_q[0]  <= cfg_data;
				REG_ORIGIN_Y: org_q[1]  <= cfg_data;
				REG_ORIGIN_Z: org_q[2]  <= cfg_data;
				REG_DIR_X:    dir_q[0]  <= cfg_data;
				REG_DIR_Y:    dir_q[1]  <= cfg_data;
				REG_DIR_Z:    dir_q[2]  <= cfg_data;
				REG_DET_MIN:  det_min_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// direction widened to edge width so every product is uniform
	edge_t dir_w [3];
	always_comb begin
		for (int i = 0; i < 3; i++) dir_w[i] = EdgeW'(dir_q[i]);
	end

	// ---- pipe control: whole pipe moves unless the output item is held ----
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign in_stall = v_s8 && out_stall;
	assign en       = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ---- payload ----
	coord_t a_in [3], b_in [3], c_in [3];
	always_comb begin
		a_in[0] = a_x; a_in[1] = a_y; a_in[2] = a_z;
		b_in[0] = b_x; b_in[1] = b_y; b_in[2] = b_z;
		c_in[0] = c_x; c_in[1] = c_y; c_in[2] = c_z;
	end

	// s1: edges and origin offset
	edge_t e1_s1 [3], e2_s1 [3], t_s1 [3];
	// s2: cross-product terms (P from dir x e2, Q from T x e1)
	cross_t mp_s2 [3][2], mq_s2 [3][2];
	edge_t  e1_s2 [3], e2_s2 [3], t_s2 [3];
	// s3: P and Q
	cross_t p_s3 [3], q_s3 [3];
	edge_t  e1_s3 [3], e2_s3 [3], t_s3 [3];
	// s4: dot partials, Q/P split at bit 33 (dots: det, u, v, t)
	logic signed [EdgeW+LoW:0]    pl_s4 [4][3];
	logic signed [EdgeW+EdgeW-1:0] ph_s4 [4][3];
	// s5..s8
	dot_t term_s5 [4][3];
	dot_t dot_s6 [4];
	dot_t uv_s6;
	dot_t det_s7, un_s7, vn_s7, tn_s7, uv_s7;
	logic     hit_s8;
	verdict_t verdict_s8;

	edge_t  dot_a [4][3];
	cross_t dot_b [4][3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot_a[0][i] = e1_s3[i]; dot_b[0][i] = p_s3[i];
			dot_a[1][i] = t_s3[i];  dot_b[1][i] = p_s3[i];
			dot_a[2][i] = dir_w[i]; dot_b[2][i] = q_s3[i];
			dot_a[3][i] = e2_s3[i]; dot_b[3][i] = q_s3[i];
		end
	end

	dot_t det_pos, un_f, vn_f, tn_f, uv_f, thr;
	logic det_neg;
	verdict_t verdict_c;

	always_comb begin
		det_neg = dot_s6[0][DotW-1];
		det_pos = det_neg ? -dot_s6[0] : dot_s6[0];
		un_f    = det_neg ? -dot_s6[1] : dot_s6[1];
		vn_f    = det_neg ? -dot_s6[2] : dot_s6[2];
		tn_f    = det_neg ? -dot_s6[3] : dot_s6[3];
		uv_f    = det_neg ? -uv_s6     : uv_s6;
	end

	always_comb begin
		thr = $signed(DotW'(det_min_q)) <<< (2 * FRAC_BITS);
		if (det_s7 == '0 || det_s7 < thr)      verdict_c = VERDICT_PARALLEL;
		else if (un_s7 < 0 || det_s7 < un_s7)  verdict_c = VERDICT_U_OUT;
		else if (vn_s7 < 0 || det_s7 < uv_s7)  verdict_c = VERDICT_V_OUT;
		else if (tn_s7 <= 0)                   verdict_c = VERDICT_BEHIND;
		else                                   verdict_c = VERDICT_HIT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EdgeW'(b_in[i]) - EdgeW'(a_in[i]);
				e2_s1[i] <= EdgeW'(c_in[i]) - EdgeW'(a_in[i]);
				t_s1[i]  <= EdgeW'(org_q[i]) - EdgeW'(a_in[i]);

				mp_s2[i][0] <= dir_w[(i+1)%3] * e2_s1[(i+2)%3];
				mp_s2[i][1] <= dir_w[(i+2)%3] * e2_s1[(i+1)%3];
				mq_s2[i][0] <= t_s1[(i+1)%3] * e1_s1[(i+2)%3];
				mq_s2[i][1] <= t_s1[(i+2)%3] * e1_s1[(i+1)%3];
				e1_s2[i] <= e1_s1[i]; e2_s2[i] <= e2_s1[i]; t_s2[i] <= t_s1[i];

				p_s3[i]  <= mp_s2[i][0] - mp_s2[i][1];
				q_s3[i]  <= mq_s2[i][0] - mq_s2[i][1];
				e1_s3[i] <= e1_s2[i]; e2_s3[i] <= e2_s2[i]; t_s3[i] <= t_s2[i];

				for (int k = 0; k < 4; k++) begin
					pl_s4[k][i] <= dot_a[k][i] * $signed({1'b0, dot_b[k][i][LoW-1:0]});
					ph_s4[k][i] <= dot_a[k][i] * $signed(dot_b[k][i][CrossW-1:LoW]);
					term_s5[k][i] <= (DotW'(ph_s4[k][i]) <<< LoW) + DotW'(pl_s4[k][i]);
				end
			end
			for (int k = 0; k < 4; k++)
				dot_s6[k] <= term_s5[k][0] + term_s5[k][1] + term_s5[k][2];
			uv_s6 <= term_s5[1][0] + term_s5[1][1] + term_s5[1][2]
			       + term_s5[2][0] + term_s5[2][1] + term_s5[2][2];

			det_s7 <= det_pos;
			un_s7  <= un_f;
			vn_s7  <= vn_f;
			tn_s7  <= tn_f;
			uv_s7  <= uv_f;

			verdict_s8 <= verdict_c;
			hit_s8     <= (verdict_c == VERDICT_HIT);
		end
	end

	assign out_valid = v_s8;
	assign hit       = hit_s8;
	assign verdict   = verdict_s8;

endmodule

// File: rtl/rti_checker.sv
module rti_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input rti_pkg::verdict_t verdict
);
	import rti_pkg::*;

	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (verdict == VERDICT_HIT)))
		else $error("hit disagrees with verdict");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(verdict) && $stable(hit)))
		else $error("held output item changed");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .verdict(verdict)
);
